@@ rtl/fmin_pkg.sv @@
`timescale 1ns / 1ps

package fmin_pkg;

    localparam int DATA_W        = 32;
    localparam int OPCODE_W      = 3;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [OPCODE_W-1:0] OP_ENQ   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQ   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FRONT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SIZE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_MIN   = 3'd5;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic                     clr;
        logic signed [DATA_W-1:0] data;
    } cell_ctrl_t;

endpackage

@@ rtl/fmin_cell.sv @@
`timescale 1ns / 1ps

module fmin_cell
    import fmin_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     left_valid,
    input  logic                     nbr_valid,
    input  logic signed [DATA_W-1:0] nbr_data,
    input  logic signed [DATA_W-1:0] nbr_min,
    output logic                     valid,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] min_val
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.deq)
        begin
            valid_reg <= nbr_valid;
        end
        else if (ctrl.enq && left_valid && !valid_reg)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Each cell keeps the minimum of itself and every cell behind it.
    always_ff @(posedge clk)
    begin
        if (ctrl.deq)
        begin
            data_reg <= nbr_data;
            min_reg  <= nbr_min;
        end
        else if (ctrl.enq)
        begin
            if (valid_reg)
            begin
                if (ctrl.data < min_reg)
                begin
                    min_reg <= ctrl.data;
                end
            end
            else if (left_valid)
            begin
                data_reg <= ctrl.data;
                min_reg  <= ctrl.data;
            end
        end
    end

    assign valid   = valid_reg;
    assign data    = data_reg;
    assign min_val = min_reg;

endmodule

@@ rtl/fmin_chain.sv @@
`timescale 1ns / 1ps

module fmin_chain
    import fmin_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    output logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0] head_min
);

    logic                     valid_w [DEPTH];
    logic signed [DATA_W-1:0] data_w  [DEPTH];
    logic signed [DATA_W-1:0] min_w   [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     left_valid;
            logic                     nbr_valid;
            logic signed [DATA_W-1:0] nbr_data;
            logic signed [DATA_W-1:0] nbr_min;

            if (i == 0)
            begin : g_head
                assign left_valid = 1'b1;
            end
            else
            begin : g_body
                assign left_valid = valid_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign nbr_valid = 1'b0;
                assign nbr_data  = '0;
                assign nbr_min   = '0;
            end
            else
            begin : g_link
                assign nbr_valid = valid_w[i+1];
                assign nbr_data  = data_w[i+1];
                assign nbr_min   = min_w[i+1];
            end

            fmin_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_valid (left_valid),
                .nbr_valid  (nbr_valid),
                .nbr_data   (nbr_data),
                .nbr_min    (nbr_min),
                .valid      (valid_w[i]),
                .data       (data_w[i]),
                .min_val    (min_w[i])
            );
        end
    endgenerate

    assign head_data = data_w[0];
    assign head_min  = min_w[0];

endmodule

@@ rtl/fifo_with_running_minimum_top.sv @@
`timescale 1ns / 1ps

// Bounded FIFO of signed 32-bit values that also reports the minimum held value.
// Command channel: drive opcode and value_in with start high; the transaction is
// taken at a rising edge where start is high and busy is low.
// Opcodes: enqueue, dequeue, front, size, clear, min; 6 and 7 are invalid.
// Result channel: value_out and error are valid for exactly one cycle with done
// high, in the cycle after the command is taken. Every command yields one result.
// One command per cycle while not busy: the queue is a row of DEPTH cells, each
// holding a value and the minimum of itself and all younger values, so dequeue
// is a one-step shift toward the head and min is read from the head cell.
// Errors: dequeue, front or min on an empty queue, enqueue on a full queue and
// invalid opcodes set error with value_out zero.
// Reset clears the queue; busy is high during reset and is cleared by the clock after reset is released.
// The receiver cannot stall; results must be captured when done is high.
module fifo_with_running_minimum_top
    import fmin_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPCODE_W-1:0]      opcode,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     done,
    output logic signed [DATA_W-1:0] value_out,
    output logic                     error
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] value_out_reg;
    logic signed [DATA_W-1:0] value_out_next;
    logic                     error_reg;
    logic                     error_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     take;
    logic                     empty;
    logic                     full;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] head_min;

    assign take  = start && !busy_reg;
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        ctrl           = '0;
        ctrl.data      = value_in;
        value_out_next = '0;
        error_next     = 1'b0;
        count_next     = count_reg;
        if (take)
        begin
            unique case (opcode)
                OP_ENQ:
                begin
                    if (full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.enq   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEQ:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.deq       = 1'b1;
                        value_out_next = head_data;
                        count_next     = count_reg - 1'b1;
                    end
                end
                OP_FRONT:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        value_out_next = head_data;
                    end
                end
                OP_SIZE:
                begin
                    value_out_next = DATA_W'(count_reg);
                end
                OP_CLEAR:
                begin
                    ctrl.clr   = 1'b1;
                    count_next = '0;
                end
                OP_MIN:
                begin
                    if (empty)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        value_out_next = head_min;
                    end
                end
                default:
                begin
                    error_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            done_reg  <= take;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        error_reg     <= error_next;
    end

    fmin_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .head_data (head_data),
        .head_min  (head_min)
    );

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign error     = error_reg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import fmin_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int ITEM_COUNT  = 1450;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [OPCODE_W-1:0] OP_BAD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_BAD7 = 3'd7;

    typedef struct {
        logic [OPCODE_W-1:0]      op;
        logic signed [DATA_W-1:0] val;
    } command_t;

    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     err;
    } response_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic [OPCODE_W-1:0]      opcode   = OP_SIZE;
    logic signed [DATA_W-1:0] value_in = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] value_out;
    logic                     error;

    command_t  commands_to_send [$];
    response_t responses_due [$];

    logic signed [DATA_W-1:0] held [QUEUE_DEPTH];
    int                       held_count = 0;
    logic [5:0]               head_ptr   = '0;

    int        accepted   = 0;
    int        mismatches = 0;
    int        quiet      = 0;
    logic      took;
    response_t predicted;
    response_t expected;
    response_t seen;

    fifo_with_running_minimum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .error     (error)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic response_t queue_response(input logic [OPCODE_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] val);
        response_t                r;
        logic [5:0]               idx;
        logic signed [DATA_W-1:0] best;
        r.val = '0;
        r.err = 1'b0;
        case (op)
            OP_ENQ: begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.err = 1'b1;
                end
                else begin
                    idx = head_ptr + 6'(held_count);
                    held[idx] = val;
                    held_count++;
                end
            end
            OP_DEQ: begin
                if (held_count == 0) begin
                    r.err = 1'b1;
                end
                else begin
                    r.val = held[head_ptr];
                    head_ptr = head_ptr + 6'd1;
                    held_count--;
                end
            end
            OP_FRONT: begin
                if (held_count == 0)
                    r.err = 1'b1;
                else
                    r.val = held[head_ptr];
            end
            OP_SIZE: begin
                r.val = held_count;
            end
            OP_CLEAR: begin
                held_count = 0;
                head_ptr = '0;
            end
            OP_MIN: begin
                if (held_count == 0) begin
                    r.err = 1'b1;
                end
                else begin
                    best = held[head_ptr];
                    for (int k = 1; k < held_count; k++) begin
                        idx = head_ptr + 6'(k);
                        if (held[idx] < best)
                            best = held[idx];
                    end
                    r.val = best;
                end
            end
            default: begin
                r.err = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = -32'sd1;
            3:       v = '0;
            4, 5:    v = $signed($urandom_range(0, 40)) - 32'sd20;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add(input logic [OPCODE_W-1:0] op, input logic signed [DATA_W-1:0] val);
        command_t c;
        c.op  = op;
        c.val = val;
        commands_to_send.push_back(c);
    endtask

    function automatic logic [OPCODE_W-1:0] pick_mixed_op();
        int roll;
        logic [OPCODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            op = OP_ENQ;
        else if (roll < 60)
            op = OP_DEQ;
        else if (roll < 68)
            op = OP_FRONT;
        else if (roll < 76)
            op = OP_SIZE;
        else if (roll < 91)
            op = OP_MIN;
        else if (roll < 94)
            op = OP_CLEAR;
        else if (roll < 97)
            op = OP_BAD6;
        else
            op = OP_BAD7;
        return op;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 1'b0;
            opcode   <= OP_SIZE;
            value_in <= '0;
        end
        else begin
            took = start && !busy;
            if (took) begin
                predicted = queue_response(opcode, value_in);
                responses_due.push_back(predicted);
                void'(commands_to_send.pop_front());
                accepted++;
            end
            if (start && !took) begin
                // hold the transaction until it is taken
            end
            else if (commands_to_send.size() > 0 &&
                     ((accepted >= 500 && accepted < 800) || $urandom_range(0, 99) >= 15)) begin
                start    <= 1'b1;
                opcode   <= commands_to_send[0].op;
                value_in <= commands_to_send[0].val;
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            seen.val = value_out;
            seen.err = error;
            if (responses_due.size() == 0) begin
                $display("%0t: unexpected transaction value_out %0d error %0b",
                         $time, seen.val, seen.err);
                mismatches++;
            end
            else begin
                expected = responses_due.pop_front();
                if (seen.val !== expected.val) begin
                    $display("%0t: value_out expected %0d actual %0d",
                             $time, expected.val, seen.val);
                    mismatches++;
                end
                if (seen.err !== expected.err) begin
                    $display("%0t: error expected %0b actual %0b",
                             $time, expected.err, seen.err);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int kind;

        add(OP_MIN, 0);
        add(OP_DEQ, 0);
        add(OP_FRONT, 0);
        add(OP_SIZE, 0);
        add(OP_BAD6, 32'sh1234_5678);
        add(OP_BAD7, -32'sd1);
        add(OP_CLEAR, 0);
        add(OP_ENQ, 32'sh7fff_ffff);
        add(OP_ENQ, -32'sd1);
        add(OP_ENQ, 32'sh8000_0000);
        add(OP_ENQ, 0);
        add(OP_MIN, 0);
        add(OP_FRONT, 0);
        add(OP_SIZE, 0);
        add(OP_DEQ, 0);
        add(OP_MIN, 0);
        add(OP_DEQ, 0);
        add(OP_MIN, 0);
        add(OP_ENQ, 32'sd5);
        add(OP_CLEAR, 0);
        add(OP_SIZE, 0);
        add(OP_FRONT, 0);
        add(OP_ENQ, 32'sh5555_5555);
        add(OP_ENQ, 32'shAAAA_AAAA);
        add(OP_DEQ, 0);

        while (commands_to_send.size() < ITEM_COUNT) begin
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // fill up to or past full, peeking now and then
                if ($urandom_range(0, 2) == 0)
                    add(OP_CLEAR, 0);
                n = $urandom_range(60, 72);
                for (int i = 0; i < n; i++) begin
                    add(OP_ENQ, pick_value());
                    if ($urandom_range(0, 7) == 0)
                        add($urandom_range(0, 1) ? OP_MIN : OP_SIZE, pick_value());
                end
                add(OP_SIZE, 0);
                add(OP_MIN, 0);
            end
            else if (kind < 40) begin
                // drain toward or past empty
                n = $urandom_range(60, 72);
                for (int i = 0; i < n; i++) begin
                    add(OP_DEQ, pick_value());
                    if ($urandom_range(0, 3) == 0)
                        add($urandom_range(0, 1) ? OP_MIN : OP_FRONT, pick_value());
                end
            end
            else begin
                for (int i = 0; i < 20; i++)
                    add(pick_mixed_op(), pick_value());
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (commands_to_send.size() == 0);
        wait (responses_due.size() == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && responses_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
